/* rtl/special_function_register_bank_top_defines.svh */
// Assertion macros for the register bank checker.
`ifndef SPECIAL_FUNCTION_REGISTER_BANK_TOP_DEFINES_SVH
`define SPECIAL_FUNCTION_REGISTER_BANK_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define SFRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent sequence implies a consequent in the next cycle.
`define SFRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sfrb_pkg.sv */
package sfrb_pkg;

  // Access kinds carried by one word
  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_RESUME = 2'd2,
    FUNC_NOP    = 2'd3
  } sfrb_func_e;

  // Resume line selects
  localparam logic [1:0] RESUME_LINE0 = 2'd0;
  localparam logic [1:0] RESUME_LINE1 = 2'd1;
  localparam logic [1:0] RESUME_LINE2 = 2'd2;

  // Register byte offsets
  localparam logic [9:0] OFS_EBICSA = 10'h004;
  localparam logic [9:0] OFS_ICR    = 10'h010;
  localparam logic [9:0] OFS_ISR    = 10'h014;
  localparam logic [9:0] OFS_HSTRIM = 10'h034;
  localparam logic [9:0] OFS_FSTRIM = 10'h038;
  localparam logic [9:0] OFS_SWAP   = 10'h03c;
  localparam logic [9:0] OFS_LS     = 10'h0a0;
  localparam logic [9:0] OFS_CAL    = 10'h0b4;
  localparam logic [9:0] OFS_PROT   = 10'h0e4;
  localparam logic [9:0] OFS_PUFCTL = 10'h200;
  localparam logic [9:0] OFS_PUFDIS = 10'h208;
  localparam logic [9:0] OFS_UCR0   = 10'h20c;
  localparam logic [9:0] OFS_UCR1   = 10'h210;
  localparam logic [9:0] OFS_WOUCR0 = 10'h214;
  localparam logic [9:0] OFS_WOUCR1 = 10'h218;
  localparam logic [9:0] OFS_CLKG   = 10'h220;
  localparam logic [9:0] OFS_ISS    = 10'h240;
  localparam logic [9:0] OFS_TSU    = 10'h250;
  localparam logic [9:0] OFS_REMAP  = 10'h260;

  // Protect register key
  localparam logic [31:0] PROT_KEY      = 32'h5346_5200;
  localparam logic [31:0] PROT_KEY_MASK = 32'hffff_ff00;

  // Writable bits, and the PUFCTL bits that a write keeps, at the width of each register
  localparam logic [25:0] EBI_WMASK    = 26'h310_0306;
  localparam logic [10:0] ICR_WMASK    = 11'h717;
  localparam logic [18:0] HS_WMASK     = 19'h7_7700;
  localparam logic [30:0] FS_WMASK     = 31'h7777_0000;
  localparam logic [16:0] LS_WMASK     = 17'h1_3fff;
  localparam logic [9:0]  PUFCTL_KEEP  = 10'h310;
  localparam logic [9:0]  PUFCTL_WMASK = 10'h07f;

  // Reset values
  localparam logic [25:0] EBI_RST    = 26'h300;
  localparam logic [18:0] HS_RST     = 19'h4_4433;
  localparam logic [30:0] FS_RST     = 31'h43_0211;
  localparam logic [8:0]  CAL_RST    = 9'h084;
  localparam logic [9:0]  PUFCTL_RST = 10'h148;
  localparam logic [7:0]  TSU_RST    = 8'h43;

  // Resume interrupt enable bit of the interrupt control register
  localparam int unsigned ICR_ARIE_BIT = 4;

  // One access as it leaves the input register
  typedef struct packed {
    sfrb_func_e  func;
    logic [9:0]  byte_offset;
    logic [31:0] write_data;
    logic [1:0]  resume_line;
    logic        resume_level;
  } sfrb_req_t;

  // Result of one access
  typedef struct packed {
    logic [31:0] read_data;
    logic        interrupt_out;
  } sfrb_rsp_t;

endpackage

/* rtl/sfrb_regfile.sv */
module sfrb_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  sfrb_pkg::sfrb_req_t req_i,
  output sfrb_pkg::sfrb_rsp_t rsp_o
);

  logic [25:0] ebi_q, ebi_d;
  logic [10:0] icr_q, icr_d;
  logic [2:0]  isr_q, isr_d;
  logic [18:0] hs_q, hs_d;
  logic [30:0] fs_q, fs_d;
  logic [2:0]  swap_q, swap_d;
  logic [16:0] ls_q, ls_d;
  logic [8:0]  cal_q, cal_d;
  logic        wpe_q, wpe_d;
  logic [9:0]  pufctl_q, pufctl_d;
  logic [12:0] pufdis_q, pufdis_d;
  logic [31:0] ucr0_q, ucr0_d;
  logic [31:0] ucr1_q, ucr1_d;
  logic [31:0] woucr0_q, woucr0_d;
  logic [31:0] woucr1_q, woucr1_d;
  logic [1:0]  clkg_q, clkg_d;
  logic        iss_q, iss_d;
  logic [7:0]  tsu_q, tsu_d;
  logic [13:0] remap_q, remap_d;
  logic [31:0] wd;
  logic [31:0] rdata;

  assign wd = req_i.write_data;

  // Work out the next state for the word being processed
  always_comb begin
    ebi_d    = ebi_q;
    icr_d    = icr_q;
    isr_d    = isr_q;
    hs_d     = hs_q;
    fs_d     = fs_q;
    swap_d   = swap_q;
    ls_d     = ls_q;
    cal_d    = cal_q;
    wpe_d    = wpe_q;
    pufctl_d = pufctl_q;
    pufdis_d = pufdis_q;
    ucr0_d   = ucr0_q;
    ucr1_d   = ucr1_q;
    woucr0_d = woucr0_q;
    woucr1_d = woucr1_q;
    clkg_d   = clkg_q;
    iss_d    = iss_q;
    tsu_d    = tsu_q;
    remap_d  = remap_q;
    if (fire_i) begin
      unique case (req_i.func)
        sfrb_pkg::FUNC_WRITE: begin
          if (req_i.byte_offset == sfrb_pkg::OFS_PROT) begin
            // only a keyed write moves the protect bit
            if ((wd & sfrb_pkg::PROT_KEY_MASK) == sfrb_pkg::PROT_KEY) begin
              wpe_d = wd[0];
            end
          end else if (!wpe_q) begin
            unique case (req_i.byte_offset)
              sfrb_pkg::OFS_EBICSA: ebi_d = wd[25:0] & sfrb_pkg::EBI_WMASK;
              sfrb_pkg::OFS_ICR:    icr_d = wd[10:0] & sfrb_pkg::ICR_WMASK;
              sfrb_pkg::OFS_HSTRIM: hs_d = (hs_q & ~sfrb_pkg::HS_WMASK)
                                         | (wd[18:0] & sfrb_pkg::HS_WMASK);
              sfrb_pkg::OFS_FSTRIM: fs_d = (fs_q & ~sfrb_pkg::FS_WMASK)
                                         | (wd[30:0] & sfrb_pkg::FS_WMASK);
              sfrb_pkg::OFS_SWAP:   swap_d = wd[2:0];
              sfrb_pkg::OFS_LS:     ls_d = wd[16:0] & sfrb_pkg::LS_WMASK;
              sfrb_pkg::OFS_CAL:    cal_d = wd[8:0];
              // keep the trim bits and the sticky disable bit
              sfrb_pkg::OFS_PUFCTL: pufctl_d = (pufctl_q & sfrb_pkg::PUFCTL_KEEP)
                                             | (wd[9:0] & sfrb_pkg::PUFCTL_WMASK);
              sfrb_pkg::OFS_PUFDIS: pufdis_d = pufdis_q | wd[12:0];
              sfrb_pkg::OFS_UCR0:   ucr0_d = wd;
              sfrb_pkg::OFS_UCR1:   ucr1_d = wd;
              sfrb_pkg::OFS_WOUCR0: woucr0_d = woucr0_q | wd;
              sfrb_pkg::OFS_WOUCR1: woucr1_d = woucr1_q | wd;
              sfrb_pkg::OFS_CLKG:   clkg_d = wd[1:0];
              sfrb_pkg::OFS_ISS:    iss_d = wd[0];
              sfrb_pkg::OFS_TSU:    tsu_d = wd[7:0];
              sfrb_pkg::OFS_REMAP:  remap_d = wd[13:0];
              default: ;
            endcase
          end
        end
        sfrb_pkg::FUNC_RESUME: begin
          // the fourth line code does nothing
          case (req_i.resume_line)
            sfrb_pkg::RESUME_LINE0: isr_d[0] = req_i.resume_level;
            sfrb_pkg::RESUME_LINE1: isr_d[1] = req_i.resume_level;
            sfrb_pkg::RESUME_LINE2: isr_d[2] = req_i.resume_level;
            default: ;
          endcase
        end
        sfrb_pkg::FUNC_READ, sfrb_pkg::FUNC_NOP: ;
        default: ;
      endcase
    end
  end

  // Select the addressed register for a read
  always_comb begin
    rdata = '0;
    unique case (req_i.byte_offset)
      sfrb_pkg::OFS_EBICSA: rdata = 32'(ebi_q);
      sfrb_pkg::OFS_ICR:    rdata = 32'(icr_q);
      sfrb_pkg::OFS_ISR:    rdata = 32'(isr_q);
      sfrb_pkg::OFS_HSTRIM: rdata = 32'(hs_q);
      sfrb_pkg::OFS_FSTRIM: rdata = 32'(fs_q);
      sfrb_pkg::OFS_SWAP:   rdata = 32'(swap_q);
      sfrb_pkg::OFS_LS:     rdata = 32'(ls_q);
      sfrb_pkg::OFS_CAL:    rdata = 32'(cal_q);
      sfrb_pkg::OFS_PROT:   rdata = 32'(wpe_q);
      sfrb_pkg::OFS_PUFCTL: rdata = 32'(pufctl_q);
      sfrb_pkg::OFS_PUFDIS: rdata = 32'(pufdis_q);
      sfrb_pkg::OFS_UCR0:   rdata = ucr0_q;
      sfrb_pkg::OFS_UCR1:   rdata = ucr1_q;
      sfrb_pkg::OFS_WOUCR0: rdata = woucr0_q;
      sfrb_pkg::OFS_WOUCR1: rdata = woucr1_q;
      sfrb_pkg::OFS_CLKG:   rdata = 32'(clkg_q);
      sfrb_pkg::OFS_ISS:    rdata = 32'(iss_q);
      sfrb_pkg::OFS_TSU:    rdata = 32'(tsu_q);
      sfrb_pkg::OFS_REMAP:  rdata = 32'(remap_q);
      default:              rdata = '0;
    endcase
  end

  // Drive the result: data only for reads, interrupt from the updated state
  assign rsp_o.read_data     = (req_i.func == sfrb_pkg::FUNC_READ) ? rdata : '0;
  assign rsp_o.interrupt_out = icr_d[sfrb_pkg::ICR_ARIE_BIT] & (|isr_d);

  // Hold the register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ebi_q    <= sfrb_pkg::EBI_RST;
      icr_q    <= '0;
      isr_q    <= '0;
      hs_q     <= sfrb_pkg::HS_RST;
      fs_q     <= sfrb_pkg::FS_RST;
      swap_q   <= '0;
      ls_q     <= '0;
      cal_q    <= sfrb_pkg::CAL_RST;
      wpe_q    <= 1'b0;
      pufctl_q <= sfrb_pkg::PUFCTL_RST;
      pufdis_q <= '0;
      ucr0_q   <= '0;
      ucr1_q   <= '0;
      woucr0_q <= '0;
      woucr1_q <= '0;
      clkg_q   <= '0;
      iss_q    <= 1'b0;
      tsu_q    <= sfrb_pkg::TSU_RST;
      remap_q  <= '0;
    end else begin
      ebi_q    <= ebi_d;
      icr_q    <= icr_d;
      isr_q    <= isr_d;
      hs_q     <= hs_d;
      fs_q     <= fs_d;
      swap_q   <= swap_d;
      ls_q     <= ls_d;
      cal_q    <= cal_d;
      wpe_q    <= wpe_d;
      pufctl_q <= pufctl_d;
      pufdis_q <= pufdis_d;
      ucr0_q   <= ucr0_d;
      ucr1_q   <= ucr1_d;
      woucr0_q <= woucr0_d;
      woucr1_q <= woucr1_d;
      clkg_q   <= clkg_d;
      iss_q    <= iss_d;
      tsu_q    <= tsu_d;
      remap_q  <= remap_d;
    end
  end

endmodule

/* rtl/special_function_register_bank_top.sv */
// Path: an accepted word goes to the input register, then its result to the result register.
// Throughput: one word per cycle while the output is not stalled; the register bank updates
// in the cycle a word is processed. The input stage stalls only while a result word waits
// and the output is stalled. Reset (rst_ni low, asynchronous) empties both stages and loads
// every register's reset value; the bank accepts a word as soon as reset is released.
module special_function_register_bank_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [9:0]  byte_offset_i,
  input  logic [31:0] write_data_i,
  input  logic [1:0]  resume_line_i,
  input  logic        resume_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        interrupt_out_o
);

  logic                in_valid_q, in_valid_d;
  sfrb_pkg::sfrb_req_t req_q;
  logic                out_valid_q, out_valid_d;
  sfrb_pkg::sfrb_rsp_t rsp_q;
  sfrb_pkg::sfrb_rsp_t rsp;
  logic                out_ready;
  logic                fire;
  logic                in_accept;

  // Handshake: process a word when the result register is free or being taken
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold the control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.func         <= sfrb_pkg::sfrb_func_e'(func_i);
      req_q.byte_offset  <= byte_offset_i;
      req_q.write_data   <= write_data_i;
      req_q.resume_line  <= resume_line_i;
      req_q.resume_level <= resume_level_i;
    end
  end

  sfrb_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rsp_q.read_data;
  assign interrupt_out_o = rsp_q.interrupt_out;

endmodule

/* rtl/sfrb_checker.sv */
`include "special_function_register_bank_top_defines.svh"

module sfrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  func_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic        interrupt_out_o
);

  // A stalled result word holds
  `SFRB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(read_data_o) && $stable(interrupt_out_o), "result word changed while stalled")

  // The input side stalls only behind a stalled result
  `SFRB_ASSERT(a_stall_cause, !in_stall_o || (out_valid_o && out_stall_i), "input stalled without output back-pressure")

  // A non-read word that meets an empty pipeline comes out with zero data
  `SFRB_ASSERT_NEXT(a_nonread_zero, (in_valid_i && !in_stall_o && func_i != sfrb_pkg::FUNC_READ) ##1 !out_valid_o, out_valid_o && read_data_o == 32'd0, "non-read word carried data")

endmodule

bind special_function_register_bank_top sfrb_checker u_sfrb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .func_i          (func_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .read_data_o     (read_data_o),
  .interrupt_out_o (interrupt_out_o)
);

/* test/tb_special_function_register_bank_top.sv */
module tb_special_function_register_bank_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned WORDS_PER_PHASE = 530;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS  = 10;

  // Writable bits of each register, at its own width
  localparam logic [25:0] EBI_BITS = 26'h310_0306;
  localparam logic [10:0] ICR_BITS = 11'h717;
  localparam logic [18:0] HS_BITS  = 19'h7_7700;
  localparam logic [30:0] FS_BITS  = 31'h7777_0000;
  localparam logic [16:0] LS_BITS  = 17'h1_3fff;
  localparam logic [9:0]  PUF_HELD = 10'h310;
  localparam logic [9:0]  PUF_BITS = 10'h07f;

  typedef struct {
    sfrb_pkg::sfrb_func_e func;
    logic [9:0]           ofs;
    logic [31:0]          data;
    logic [1:0]           line;
    logic                 level;
  } access_t;

  typedef struct {
    logic [31:0] rdata;
    logic        irq;
  } bank_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = 2'd0;
  logic [9:0]  byte_offset = 10'd0;
  logic [31:0] write_data = 32'd0;
  logic [1:0]  resume_line = 2'd0;
  logic        resume_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        interrupt_out;

  special_function_register_bank_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .byte_offset_i  (byte_offset),
    .write_data_i   (write_data),
    .resume_line_i  (resume_line),
    .resume_level_i (resume_level),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_data_o    (read_data),
    .interrupt_out_o(interrupt_out)
  );

  // Shadow copy of the register bank, loaded with its reset values
  logic [25:0] sh_ebi    = 26'h300;
  logic [10:0] sh_icr    = '0;
  logic [2:0]  sh_isr    = '0;
  logic [18:0] sh_hs     = 19'h4_4433;
  logic [30:0] sh_fs     = 31'h43_0211;
  logic [2:0]  sh_swap   = '0;
  logic [16:0] sh_ls     = '0;
  logic [8:0]  sh_cal    = 9'h084;
  logic        sh_wp     = 1'b0;
  logic [9:0]  sh_pufctl = 10'h148;
  logic [12:0] sh_pufdis = '0;
  logic [31:0] sh_ucr [2] = '{32'd0, 32'd0};
  logic [31:0] sh_woucr [2] = '{32'd0, 32'd0};
  logic [1:0]  sh_clkg   = '0;
  logic        sh_iss    = 1'b0;
  logic [7:0]  sh_tsu    = 8'h43;
  logic [13:0] sh_remap  = '0;

  access_t     pending_words [$];
  bank_rsp_t   predicted_rsp [$];
  access_t     cur_word;
  bank_rsp_t   got_rsp;
  bank_rsp_t   want_rsp;
  logic [9:0]  reg_offsets [19];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned n_reads = 0;
  int unsigned n_writes = 0;
  int unsigned n_locked_writes = 0;
  int unsigned n_resume = 0;
  int unsigned n_nop = 0;
  int unsigned n_checked = 0;

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one access to the shadow bank and return the word the block should give
  function automatic bank_rsp_t apply_access(access_t a);
    bank_rsp_t r;
    r.rdata = '0;
    case (a.func)
      sfrb_pkg::FUNC_READ: begin
        case (a.ofs)
          sfrb_pkg::OFS_EBICSA: r.rdata = 32'(sh_ebi);
          sfrb_pkg::OFS_ICR:    r.rdata = 32'(sh_icr);
          sfrb_pkg::OFS_ISR:    r.rdata = 32'(sh_isr);
          sfrb_pkg::OFS_HSTRIM: r.rdata = 32'(sh_hs);
          sfrb_pkg::OFS_FSTRIM: r.rdata = 32'(sh_fs);
          sfrb_pkg::OFS_SWAP:   r.rdata = 32'(sh_swap);
          sfrb_pkg::OFS_LS:     r.rdata = 32'(sh_ls);
          sfrb_pkg::OFS_CAL:    r.rdata = 32'(sh_cal);
          sfrb_pkg::OFS_PROT:   r.rdata = 32'(sh_wp);
          sfrb_pkg::OFS_PUFCTL: r.rdata = 32'(sh_pufctl);
          sfrb_pkg::OFS_PUFDIS: r.rdata = 32'(sh_pufdis);
          sfrb_pkg::OFS_UCR0:   r.rdata = sh_ucr[0];
          sfrb_pkg::OFS_UCR1:   r.rdata = sh_ucr[1];
          sfrb_pkg::OFS_WOUCR0: r.rdata = sh_woucr[0];
          sfrb_pkg::OFS_WOUCR1: r.rdata = sh_woucr[1];
          sfrb_pkg::OFS_CLKG:   r.rdata = 32'(sh_clkg);
          sfrb_pkg::OFS_ISS:    r.rdata = 32'(sh_iss);
          sfrb_pkg::OFS_TSU:    r.rdata = 32'(sh_tsu);
          sfrb_pkg::OFS_REMAP:  r.rdata = 32'(sh_remap);
          default:              r.rdata = '0;
        endcase
      end
      sfrb_pkg::FUNC_WRITE: begin
        if (a.ofs == sfrb_pkg::OFS_PROT) begin
          // Protect register only takes a write that carries the key
          if ((a.data & sfrb_pkg::PROT_KEY_MASK) == sfrb_pkg::PROT_KEY) sh_wp = a.data[0];
        end else if (!sh_wp) begin
          case (a.ofs)
            sfrb_pkg::OFS_EBICSA: sh_ebi = a.data[25:0] & EBI_BITS;
            sfrb_pkg::OFS_ICR:    sh_icr = a.data[10:0] & ICR_BITS;
            sfrb_pkg::OFS_HSTRIM: sh_hs = (sh_hs & ~HS_BITS) | (a.data[18:0] & HS_BITS);
            sfrb_pkg::OFS_FSTRIM: sh_fs = (sh_fs & ~FS_BITS) | (a.data[30:0] & FS_BITS);
            sfrb_pkg::OFS_SWAP:   sh_swap = a.data[2:0];
            sfrb_pkg::OFS_LS:     sh_ls = a.data[16:0] & LS_BITS;
            sfrb_pkg::OFS_CAL:    sh_cal = a.data[8:0];
            sfrb_pkg::OFS_PUFCTL:
              sh_pufctl = (sh_pufctl & PUF_HELD) | (a.data[9:0] & PUF_BITS);
            sfrb_pkg::OFS_PUFDIS: sh_pufdis = sh_pufdis | a.data[12:0];
            sfrb_pkg::OFS_UCR0:   sh_ucr[0] = a.data;
            sfrb_pkg::OFS_UCR1:   sh_ucr[1] = a.data;
            sfrb_pkg::OFS_WOUCR0: sh_woucr[0] = sh_woucr[0] | a.data;
            sfrb_pkg::OFS_WOUCR1: sh_woucr[1] = sh_woucr[1] | a.data;
            sfrb_pkg::OFS_CLKG:   sh_clkg = a.data[1:0];
            sfrb_pkg::OFS_ISS:    sh_iss = a.data[0];
            sfrb_pkg::OFS_TSU:    sh_tsu = a.data[7:0];
            sfrb_pkg::OFS_REMAP:  sh_remap = a.data[13:0];
            default: ;
          endcase
        end
      end
      sfrb_pkg::FUNC_RESUME: begin
        if (a.line <= sfrb_pkg::RESUME_LINE2) sh_isr[a.line] = a.level;
      end
      default: ;
    endcase
    r.irq = sh_icr[sfrb_pkg::ICR_ARIE_BIT] && (sh_isr != 3'd0);
    return r;
  endfunction

  // Build one word from the fields given
  function automatic access_t make_word(sfrb_pkg::sfrb_func_e f, logic [9:0] o,
                                        logic [31:0] d, logic [1:0] l, logic v);
    access_t a;
    a.func  = f;
    a.ofs   = o;
    a.data  = d;
    a.line  = l;
    a.level = v;
    return a;
  endfunction

  // Random word, biased towards mapped registers and keyed protect writes
  function automatic access_t random_word();
    access_t     a;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40)      a.func = sfrb_pkg::FUNC_READ;
    else if (r < 80) a.func = sfrb_pkg::FUNC_WRITE;
    else if (r < 95) a.func = sfrb_pkg::FUNC_RESUME;
    else             a.func = sfrb_pkg::FUNC_NOP;
    r = $urandom_range(99);
    if (r < 80)      a.ofs = reg_offsets[$urandom_range(18)];
    else if (r < 90) a.ofs = 10'($urandom_range(1023));
    else             a.ofs = reg_offsets[$urandom_range(18)] ^ 10'($urandom_range(3, 1));
    a.data = $urandom;
    if (a.ofs == sfrb_pkg::OFS_PROT && $urandom_range(99) < 60) begin
      a.data = sfrb_pkg::PROT_KEY | {24'd0, 7'($urandom), 1'($urandom_range(99) < 30)};
    end else if ((a.ofs == sfrb_pkg::OFS_PUFDIS || a.ofs == sfrb_pkg::OFS_WOUCR0
                  || a.ofs == sfrb_pkg::OFS_WOUCR1) && $urandom_range(99) < 97) begin
      // Keep sticky registers from filling up at once
      a.data = ($urandom_range(3) == 0) ? 32'd0 : (32'd1 << $urandom_range(31));
    end
    a.line  = 2'($urandom_range(3));
    a.level = 1'($urandom_range(1));
    return a;
  endfunction

  // Driver: predict each accepted word, then offer the next or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        case (cur_word.func)
          sfrb_pkg::FUNC_READ:   n_reads++;
          sfrb_pkg::FUNC_WRITE: begin
            n_writes++;
            if (sh_wp && cur_word.ofs != sfrb_pkg::OFS_PROT) n_locked_writes++;
          end
          sfrb_pkg::FUNC_RESUME: n_resume++;
          default:               n_nop++;
        endcase
        predicted_rsp.push_back(apply_access(cur_word));
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_word     = pending_words.pop_front();
          in_valid     <= 1'b1;
          func         <= cur_word.func;
          byte_offset  <= cur_word.ofs;
          write_data   <= cur_word.data;
          resume_line  <= cur_word.line;
          resume_level <= cur_word.level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or a long hold when one is asked for
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_served < holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      got_rsp.rdata = read_data;
      got_rsp.irq   = interrupt_out;
      if (predicted_rsp.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: result word with nothing expected: rdata=%h irq=%b",
                   got_rsp.rdata, got_rsp.irq);
      end else begin
        want_rsp = predicted_rsp.pop_front();
        n_checked++;
        if (got_rsp.rdata !== want_rsp.rdata || got_rsp.irq !== want_rsp.irq) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: word %0d: rdata exp %h got %h, irq exp %b got %b",
                     n_checked, want_rsp.rdata, got_rsp.rdata, want_rsp.irq, got_rsp.irq);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    reg_offsets = '{sfrb_pkg::OFS_EBICSA, sfrb_pkg::OFS_ICR, sfrb_pkg::OFS_ISR,
                    sfrb_pkg::OFS_HSTRIM, sfrb_pkg::OFS_FSTRIM, sfrb_pkg::OFS_SWAP,
                    sfrb_pkg::OFS_LS, sfrb_pkg::OFS_CAL, sfrb_pkg::OFS_PROT,
                    sfrb_pkg::OFS_PUFCTL, sfrb_pkg::OFS_PUFDIS, sfrb_pkg::OFS_UCR0,
                    sfrb_pkg::OFS_UCR1, sfrb_pkg::OFS_WOUCR0, sfrb_pkg::OFS_WOUCR1,
                    sfrb_pkg::OFS_CLKG, sfrb_pkg::OFS_ISS, sfrb_pkg::OFS_TSU,
                    sfrb_pkg::OFS_REMAP};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values, masking, sticky bits, interrupt, protection, odd offsets
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, sfrb_pkg::OFS_EBICSA,
                                      $urandom, 2'd0, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, sfrb_pkg::OFS_HSTRIM,
                                      $urandom, 2'd1, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, sfrb_pkg::OFS_FSTRIM,
                                      $urandom, 2'd2, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, sfrb_pkg::OFS_PUFCTL,
                                      $urandom, 2'd3, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_EBICSA,
                                      32'hffff_ffff, 2'd3, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_HSTRIM,
                                      32'hffff_ffff, 2'd0, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_FSTRIM,
                                      32'h0000_0000, 2'd1, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_PUFCTL,
                                      32'hffff_ffff, 2'd2, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_PUFCTL,
                                      32'h0000_0000, 2'd0, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, sfrb_pkg::OFS_PUFCTL,
                                      $urandom, 2'd1, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_ICR,
                                      32'h0000_0010, 2'd2, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_RESUME, sfrb_pkg::OFS_ISR,
                                      $urandom, sfrb_pkg::RESUME_LINE2, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_ISR,
                                      32'hffff_ffff, 2'd0, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_RESUME, sfrb_pkg::OFS_ISR,
                                      $urandom, 2'd3, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_RESUME, sfrb_pkg::OFS_ISR,
                                      $urandom, sfrb_pkg::RESUME_LINE2, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_PROT,
                                      32'h5346_5101, 2'd1, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_PROT,
                                      sfrb_pkg::PROT_KEY | 32'd1, 2'd2, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_CAL,
                                      32'h0000_0000, 2'd3, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, sfrb_pkg::OFS_CAL,
                                      $urandom, 2'd0, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_PROT,
                                      sfrb_pkg::PROT_KEY, 2'd1, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_NOP, sfrb_pkg::OFS_EBICSA,
                                      32'hffff_ffff, 2'd2, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, 10'h005,
                                      $urandom, 2'd3, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, 10'h3ff,
                                      $urandom, 2'd0, 1'b0));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_WRITE, sfrb_pkg::OFS_WOUCR0,
                                      32'h0000_0001, 2'd1, 1'b1));
    pending_words.push_back(make_word(sfrb_pkg::FUNC_READ, sfrb_pkg::OFS_ISR,
                                      $urandom, 2'd2, 1'b0));

    // Random phases: receiver idles more, then sender, then neither
    for (int phase = 0; phase < 3; phase++) begin
      // Pause the sender until every result word has arrived
      while (pending_words.size() > 0 || predicted_rsp.size() > 0 || in_valid)
        @(posedge clk_i);
      case (phase)
        0: begin tx_idle_pct = 28; rx_idle_pct = 74; end
        1: begin tx_idle_pct = 74; rx_idle_pct = 28; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) pending_words.push_back(random_word());
      // Hold the output off while the sender keeps offering, so both stages fill
      if (phase == 2) holds_asked = holds_asked + 1;
    end

    // Drain
    while (pending_words.size() > 0 || predicted_rsp.size() > 0 || in_valid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d reads, %0d writes (%0d while locked), %0d resume events, %0d nops",
             n_reads, n_writes, n_locked_writes, n_resume, n_nop);
    $display("Checked %0d result words, %0d failures", n_checked, fail_count);
    if (fail_count == 0 && predicted_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* special_function_register_bank_top.f */
+incdir+rtl
rtl/sfrb_pkg.sv
rtl/sfrb_regfile.sv
rtl/special_function_register_bank_top.sv
rtl/sfrb_checker.sv
test/tb_special_function_register_bank_top.sv
